[rtl/tcp_sender_window_retransmit_unit_macros.svh]
// Assertion helpers for the sender unit
`ifndef TCP_SENDER_WINDOW_RETRANSMIT_UNIT_MACROS_SVH
`define TCP_SENDER_WINDOW_RETRANSMIT_UNIT_MACROS_SVH

// Check a property on every clock edge outside of reset
`define SWR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define SWR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/swr_pkg.sv]
`default_nettype none
package swr_pkg;

    // Command codes of an input request
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_EMPTY = 2'd3
    } t_cmd;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_INIT_RTO   = 2'd0;
    localparam logic [1:0] REG_INIT_SEQ   = 2'd1;
    localparam logic [1:0] REG_STREAM_CAP = 2'd2;

    // Result limit per request
    localparam int MAX_RES = 48;

    // Sequencer states of the back end
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_ACK,
        ST_RET_RD,
        ST_RET_CHK,
        ST_RET_END,
        ST_FILL,
        ST_TICK,
        ST_TICK_EMIT,
        ST_EMPTY,
        ST_END
    } t_state;

    // One decoded request
    typedef struct packed {
        t_cmd        cmd;
        logic [16:0] byte_count;
        logic        stream_end;
        logic [31:0] ack_number;
        logic [15:0] window_advertised;
        logic [31:0] elapsed_ms;
    } t_item;

    // One outstanding segment
    typedef struct packed {
        logic [31:0] off;
        logic [10:0] len;
        logic        syn;
        logic        fin;
    } t_entry;

    // One segment descriptor
    typedef struct packed {
        logic [31:0] seqno;
        logic [10:0] payload_length;
        logic        syn_flag;
        logic        fin_flag;
        logic        is_resend;
        logic        last;
        logic [16:0] in_flight;
        logic [7:0]  resend_count;
    } t_res;

    // Configuration write toward the back end
    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [31:0] data;
    } t_cfg_wr;

endpackage
`default_nettype wire

[rtl/swr_ram.sv]
`default_nettype none
module swr_ram #(
    parameter int Width = 45,
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/swr_front.sv]
`default_nettype none
module swr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_cmd,
    input  wire logic [16:0]   i_byte_count,
    input  wire logic          i_stream_end,
    input  wire logic [31:0]   i_ack_number,
    input  wire logic [15:0]   i_window_advertised,
    input  wire logic [31:0]   i_elapsed_ms,
    output swr_pkg::t_item     o_item,
    output logic               o_item_valid,
    input  wire logic          i_pop
);
    import swr_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      in_item;

    assign o_stall      = (r_cnt == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    // Classify the request; fields a command does not use are cleared
    always_comb begin
        in_item            = '0;
        in_item.cmd        = t_cmd'(i_cmd);
        unique case (t_cmd'(i_cmd))
            CMD_PUSH: begin
                in_item.byte_count = i_byte_count;
                in_item.stream_end = i_stream_end;
            end
            CMD_ACK: begin
                in_item.ack_number        = i_ack_number;
                in_item.window_advertised = i_window_advertised;
            end
            CMD_TICK:  in_item.elapsed_ms = i_elapsed_ms;
            CMD_EMPTY: in_item.elapsed_ms = '0;
            default:   in_item.elapsed_ms = '0;
        endcase
    end

    // Store the request in the command queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/swr_back.sv]
`default_nettype none
`include "tcp_sender_window_retransmit_unit_macros.svh"
module swr_back #(
    parameter int MaxPayload = 1452,
    parameter int QueueDepth = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  swr_pkg::t_item      i_item,
    input  wire logic           i_item_valid,
    output logic                o_pop,
    input  swr_pkg::t_cfg_wr    i_cfg,
    output logic [15:0]         o_init_rto,
    output logic [31:0]         o_init_seq,
    output logic [16:0]         o_stream_cap,
    output logic                o_valid,
    input  wire logic           i_stall,
    output swr_pkg::t_res       o_res
);
    import swr_pkg::*;

    localparam int HW = $clog2(QueueDepth);
    localparam int FW = $clog2(QueueDepth + 1);
    localparam logic [FW-1:0] QD_F  = FW'(QueueDepth);
    localparam logic [HW-1:0] QD_LAST = HW'(QueueDepth - 1);
    localparam logic [10:0]   MAXP  = 11'(MaxPayload);

    t_state       r_state, n_state;
    t_item        r_item, n_item;
    logic [HW-1:0] r_head, n_head, r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic [31:0]  r_next_off, n_next_off;
    logic [16:0]  r_flight, n_flight;
    logic [15:0]  r_peer, n_peer;
    logic [16:0]  r_buf, n_buf;
    logic         r_ended, n_ended, r_syn_done, n_syn_done, r_fin_done, n_fin_done;
    logic         r_timer_on, n_timer_on, r_retired, n_retired;
    logic [31:0]  r_elapsed, n_elapsed, r_rto, n_rto;
    logic [7:0]   r_resend, n_resend;
    logic [5:0]   r_nres, n_nres;
    logic [15:0]  r_init_rto, n_init_rto;
    logic [31:0]  r_init_seq, n_init_seq;
    logic [16:0]  r_cap, n_cap;
    logic         r_hold_v, n_hold_v, r_out_v, n_out_v;
    t_res         r_hold, n_hold, r_out, n_out;

    logic         ram_we;
    t_entry       ram_wdata, ram_rdata;
    logic [44:0]  ram_rdata_bits;

    // comb temporaries
    logic         out_free, emit_ok, can_send, emit, push_last, snd;
    t_res         e_res;
    logic [10:0]  s_len;
    logic         s_syn, s_fin;
    logic [11:0]  s_units;
    logic [17:0]  fsum;
    logic [16:0]  room, space, addb, lenw, nbuf;
    logic [31:0]  dd, rend, rr;
    logic [11:0]  eunits;
    logic [32:0]  esum;
    logic         fin_c;

    swr_ram #(.Width(45), .Depth(QueueDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_tail),
        .i_wdata(ram_wdata),
        .i_raddr(r_head),
        .o_rdata(ram_rdata_bits)
    );
    assign ram_rdata = t_entry'(ram_rdata_bits);

    assign o_init_rto   = r_init_rto;
    assign o_init_seq   = r_init_seq;
    assign o_stream_cap = r_cap;
    assign o_valid      = r_out_v;
    assign o_res        = r_out;

    // Sequence one request: bookkeeping, queue walk and segment emission
    always_comb begin
        n_state = r_state; n_item = r_item; n_head = r_head; n_tail = r_tail;
        n_fill = r_fill; n_next_off = r_next_off; n_flight = r_flight;
        n_peer = r_peer; n_buf = r_buf; n_ended = r_ended;
        n_syn_done = r_syn_done; n_fin_done = r_fin_done;
        n_timer_on = r_timer_on; n_retired = r_retired; n_elapsed = r_elapsed;
        n_rto = r_rto; n_resend = r_resend; n_nres = r_nres;
        n_init_rto = r_init_rto; n_init_seq = r_init_seq; n_cap = r_cap;
        n_hold_v = r_hold_v; n_hold = r_hold; n_out_v = r_out_v; n_out = r_out;
        o_pop = 1'b0; ram_we = 1'b0; ram_wdata = '0;
        emit = 1'b0; push_last = 1'b0; snd = 1'b0; e_res = '0;
        s_len = '0; s_syn = 1'b0; s_fin = 1'b0; s_units = '0; fsum = '0;
        room = '0; space = '0; addb = '0; lenw = '0; nbuf = '0;
        dd = '0; rend = '0; rr = '0; eunits = '0; esum = '0; fin_c = 1'b0;

        out_free = !r_out_v || !i_stall;
        emit_ok  = !r_hold_v || out_free;
        can_send = (r_fill < QD_F) && (r_nres < 6'(MAX_RES));

        // apply configuration writes
        if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_INIT_RTO: begin
                    n_init_rto = i_cfg.data[15:0];
                    if (r_resend == 8'd0) n_rto = {16'd0, i_cfg.data[15:0]};
                end
                REG_INIT_SEQ:   n_init_seq = i_cfg.data;
                REG_STREAM_CAP: n_cap = i_cfg.data[16:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_nres = '0;
                    unique case (i_item.cmd)
                        CMD_PUSH:  n_state = ST_PUSH;
                        CMD_ACK:   n_state = ST_ACK;
                        CMD_TICK:  n_state = ST_TICK;
                        default:   n_state = ST_EMPTY;
                    endcase
                end
            end
            ST_PUSH: begin
                if (!r_ended) begin
                    space = (r_cap > r_buf) ? r_cap - r_buf : 17'd0;
                    addb  = (r_item.byte_count < space) ? r_item.byte_count : space;
                    n_buf = r_buf + addb;
                    if (r_item.stream_end) n_ended = 1'b1;
                end
                n_state = ST_FILL;
            end
            ST_ACK: begin
                dd = r_item.ack_number - (r_init_seq + r_next_off);
                if (dd != 32'd0 && !dd[31]) begin
                    n_state = ST_END;
                end else begin
                    n_peer    = r_item.window_advertised;
                    n_retired = 1'b0;
                    n_state   = ST_RET_RD;
                end
            end
            ST_RET_RD: begin
                // head entry is read this cycle
                n_state = (r_fill == '0) ? ST_RET_END : ST_RET_CHK;
            end
            ST_RET_CHK: begin
                eunits = {1'b0, ram_rdata.len} + {11'd0, ram_rdata.syn}
                       + {11'd0, ram_rdata.fin};
                rend = r_init_seq + ram_rdata.off + {20'd0, eunits};
                rr   = rend - r_item.ack_number;
                if (rr == 32'd0 || rr[31]) begin
                    n_head    = (r_head == QD_LAST) ? '0 : r_head + 1'b1;
                    n_fill    = r_fill - 1'b1;
                    n_flight  = (r_flight > {5'd0, eunits}) ?
                                r_flight - {5'd0, eunits} : 17'd0;
                    n_retired = 1'b1;
                    n_state   = ST_RET_RD;
                end else begin
                    n_state = ST_RET_END;
                end
            end
            ST_RET_END: begin
                if (r_fill == '0) begin
                    n_timer_on = 1'b0;
                    n_resend   = 8'd0;
                    n_rto      = {16'd0, r_init_rto};
                end else if (r_retired) begin
                    n_elapsed = 32'd0;
                    n_resend  = 8'd0;
                    n_rto     = {16'd0, r_init_rto};
                end
                n_state = ST_FILL;
            end
            ST_FILL: begin
                if (!r_syn_done) begin
                    if (!can_send) begin
                        n_state = ST_END;
                    end else if (emit_ok) begin
                        snd = 1'b1; s_syn = 1'b1;
                        n_syn_done = 1'b1;
                        n_state = ST_END;
                    end
                end else if (r_peer != 16'd0) begin
                    if (!({1'b0, r_peer} > r_flight) || !can_send) begin
                        n_state = ST_END;
                    end else begin
                        room  = {1'b0, r_peer} - r_flight;
                        lenw  = (room < {6'd0, MAXP}) ? room : {6'd0, MAXP};
                        if (lenw > r_buf) lenw = r_buf;
                        nbuf  = r_buf - lenw;
                        fin_c = (lenw < room) && r_ended && (nbuf == 17'd0) && !r_fin_done;
                        if (lenw == 17'd0 && !fin_c) begin
                            n_state = ST_END;
                        end else if (emit_ok) begin
                            snd = 1'b1; s_len = lenw[10:0]; s_fin = fin_c;
                            n_buf = nbuf;
                            if (fin_c) n_fin_done = 1'b1;
                        end
                    end
                end else begin
                    if (r_fill != '0 || !can_send) begin
                        n_state = ST_END;
                    end else if (r_buf != 17'd0) begin
                        if (emit_ok) begin
                            snd = 1'b1; s_len = 11'd1;
                            n_buf = r_buf - 17'd1;
                            n_state = ST_END;
                        end
                    end else if (r_ended && !r_fin_done) begin
                        if (emit_ok) begin
                            snd = 1'b1; s_fin = 1'b1;
                            n_fin_done = 1'b1;
                            n_state = ST_END;
                        end
                    end else begin
                        n_state = ST_END;
                    end
                end
            end
            ST_TICK: begin
                if (r_timer_on && r_fill != '0) begin
                    esum = {1'b0, r_elapsed} + {1'b0, r_item.elapsed_ms};
                    n_elapsed = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
                    if (n_elapsed >= r_rto) begin
                        n_elapsed = 32'd0;
                        if (r_peer != 16'd0) begin
                            if (r_resend != 8'hFF) n_resend = r_resend + 8'd1;
                            n_rto = r_rto[31] ? 32'hFFFF_FFFF : {r_rto[30:0], 1'b0};
                        end
                        n_state = ST_TICK_EMIT;
                    end else begin
                        n_state = ST_END;
                    end
                end else begin
                    n_state = ST_END;
                end
            end
            ST_TICK_EMIT: begin
                if (emit_ok) begin
                    emit = 1'b1;
                    e_res.seqno          = r_init_seq + ram_rdata.off;
                    e_res.payload_length = ram_rdata.len;
                    e_res.syn_flag       = ram_rdata.syn;
                    e_res.fin_flag       = ram_rdata.fin;
                    e_res.is_resend      = 1'b1;
                    e_res.in_flight      = r_flight;
                    e_res.resend_count   = r_resend;
                    n_state = ST_END;
                end
            end
            ST_EMPTY: begin
                if (emit_ok) begin
                    emit = 1'b1;
                    e_res.seqno        = r_init_seq + r_next_off;
                    e_res.in_flight    = r_flight;
                    e_res.resend_count = r_resend;
                    n_state = ST_END;
                end
            end
            ST_END: begin
                if (!r_hold_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    push_last = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // queue a new segment
        if (snd) begin
            s_units   = {1'b0, s_len} + {11'd0, s_syn} + {11'd0, s_fin};
            ram_we    = 1'b1;
            ram_wdata = '{off: r_next_off, len: s_len, syn: s_syn, fin: s_fin};
            n_tail    = (r_tail == QD_LAST) ? '0 : r_tail + 1'b1;
            n_fill    = r_fill + 1'b1;
            fsum      = {1'b0, r_flight} + {6'd0, s_units};
            n_flight  = fsum[17] ? 17'h1FFFF : fsum[16:0];
            n_next_off = r_next_off + {20'd0, s_units};
            if (!r_timer_on) begin
                n_timer_on = 1'b1;
                n_elapsed  = 32'd0;
            end
            emit = 1'b1;
            e_res.seqno          = r_init_seq + r_next_off;
            e_res.payload_length = s_len;
            e_res.syn_flag       = s_syn;
            e_res.fin_flag       = s_fin;
            e_res.in_flight      = n_flight;
            e_res.resend_count   = r_resend;
        end

        // drain the output register
        if (!i_stall) n_out_v = 1'b0;

        // hand the held result on; the newest stays held until its fate is known
        if (emit) begin
            n_nres = r_nres + 6'd1;
            if (r_hold_v) begin
                n_out_v = 1'b1;
                n_out   = r_hold;
            end
            n_hold_v = 1'b1;
            n_hold   = e_res;
        end else if (push_last) begin
            n_out_v     = 1'b1;
            n_out       = r_hold;
            n_out.last  = 1'b1;
            n_hold_v    = 1'b0;
        end
    end

    // State machine register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_fill <= '0;
            r_next_off <= '0; r_flight <= '0; r_peer <= 16'd1; r_buf <= '0;
            r_ended <= 1'b0; r_syn_done <= 1'b0; r_fin_done <= 1'b0;
            r_timer_on <= 1'b0; r_retired <= 1'b0; r_elapsed <= '0;
            r_rto <= 32'd1000; r_resend <= '0; r_nres <= '0;
            r_init_rto <= 16'd1000; r_init_seq <= '0; r_cap <= 17'd64000;
            r_hold_v <= 1'b0; r_out_v <= 1'b0;
        end else begin
            r_head <= n_head; r_tail <= n_tail; r_fill <= n_fill;
            r_next_off <= n_next_off; r_flight <= n_flight; r_peer <= n_peer;
            r_buf <= n_buf; r_ended <= n_ended; r_syn_done <= n_syn_done;
            r_fin_done <= n_fin_done; r_timer_on <= n_timer_on;
            r_retired <= n_retired; r_elapsed <= n_elapsed; r_rto <= n_rto;
            r_resend <= n_resend; r_nres <= n_nres;
            r_init_rto <= n_init_rto; r_init_seq <= n_init_seq; r_cap <= n_cap;
            r_hold_v <= n_hold_v; r_out_v <= n_out_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    `SWR_ASSERT(a_fill_bound, (r_fill <= QD_F), "queue fill beyond depth")
    `SWR_ASSERT(a_idle_no_hold, ((r_state == ST_IDLE) |-> !r_hold_v), "held result in idle")
    `SWR_ASSERT(a_res_limit, (r_nres <= 6'(MAX_RES)), "too many results for one request")
    `SWR_ASSERT(a_fill_step, (($past(r_fill) == r_fill) || ($past(r_fill) + 1'b1 == r_fill)
        || ($past(r_fill) == r_fill + 1'b1)), "queue fill jumped")
endmodule
`default_nettype wire

[rtl/tcp_sender_window_retransmit_unit.sv]
`default_nettype none
// TCP sender sequence-space engine: takes push/ack/tick/empty requests and returns
// segment descriptors, the final one of a request marked by o_last. Requests enter
// a two-deep command queue and are carried out one at a time by a sequencer that
// owns a QueueDepth-entry outstanding-segment RAM (registered read, no clearing
// pass; entries are only read once written). Each request runs through the
// sequencer states: push adds bytes to the send buffer and then fills the window;
// an ack beyond the sent data is ignored, an accepted ack walks the queue from
// its head (read the entry, then check it), retiring acked entries, then fills the
// window; tick may resend the head entry; an empty request emits one empty segment.
// The window fill writes one segment per cycle while the output can take it.
// Output stalls hold the sequencer only when a result is due.
module tcp_sender_window_retransmit_unit #(
    parameter int MaxPayload = 1452,
    parameter int QueueDepth = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [16:0] i_byte_count,
    input  wire logic        i_stream_end,
    input  wire logic [31:0] i_ack_number,
    input  wire logic [15:0] i_window_advertised,
    input  wire logic [31:0] i_elapsed_ms,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_seqno,
    output logic [10:0]      o_payload_length,
    output logic             o_syn_flag,
    output logic             o_fin_flag,
    output logic             o_is_resend,
    output logic             o_last,
    output logic [16:0]      o_in_flight,
    output logic [7:0]       o_resend_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import swr_pkg::*;

    t_item   item;
    logic    item_valid, pop;
    t_cfg_wr cfg;
    t_res    res;
    logic [15:0] init_rto;
    logic [31:0] init_seq;
    logic [16:0] stream_cap;

    swr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_byte_count(i_byte_count), .i_stream_end(i_stream_end),
        .i_ack_number(i_ack_number), .i_window_advertised(i_window_advertised),
        .i_elapsed_ms(i_elapsed_ms), .o_item(item), .o_item_valid(item_valid),
        .i_pop(pop)
    );

    swr_back #(.MaxPayload(MaxPayload), .QueueDepth(QueueDepth)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item), .i_item_valid(item_valid),
        .o_pop(pop), .i_cfg(cfg), .o_init_rto(init_rto), .o_init_seq(init_seq),
        .o_stream_cap(stream_cap), .o_valid(o_valid), .i_stall(i_stall), .o_res(res)
    );

    // Decode register writes
    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite && pready;
    assign cfg.idx  = paddr[3:2];
    assign cfg.data = pwdata;

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_INIT_RTO:   prdata = {16'd0, init_rto};
            REG_INIT_SEQ:   prdata = init_seq;
            REG_STREAM_CAP: prdata = {15'd0, stream_cap};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_seqno          = res.seqno;
    assign o_payload_length = res.payload_length;
    assign o_syn_flag       = res.syn_flag;
    assign o_fin_flag       = res.fin_flag;
    assign o_is_resend      = res.is_resend;
    assign o_last           = res.last;
    assign o_in_flight      = res.in_flight;
    assign o_resend_count   = res.resend_count;
endmodule
`default_nettype wire
